>>> rtl/lcc_pkg.sv
// Shared types, coefficients and defaults for the two-channel lux calculator.
package lcc_pkg;

    // default parameter values
    localparam int LUX_FRAC_BITS_DEF     = 8;
    localparam int RATIO_FRAC_BITS_DEF   = 12;
    localparam int POWER_TABLE_DEPTH_DEF = 64;

    // fixed formats
    localparam int COUNT_W   = 16;
    localparam int LUX_W     = 19;
    localparam int COEF_FRAC = 24;
    localparam int POW_W     = 14;
    localparam int PROD_W    = 36;

    // Q.24 coefficients
    localparam logic [19:0] C_A1 = 20'd510027;
    localparam logic [19:0] C_B1 = 20'd1040187;
    localparam logic [19:0] C_A2 = 20'd375810;
    localparam logic [19:0] C_B2 = 20'd520094;
    localparam logic [19:0] C_A3 = 20'd214748;
    localparam logic [19:0] C_B3 = 20'd256691;
    localparam logic [19:0] C_A4 = 20'd24495;
    localparam logic [19:0] C_B4 = 20'd18790;

    // ratio bands
    typedef enum logic [2:0] {
        BAND_POW,
        BAND_LIN2,
        BAND_LIN3,
        BAND_LIN4,
        BAND_ZERO
    } t_band;

    typedef struct packed {
        logic [COUNT_W-1:0] broadband_count;
        logic [COUNT_W-1:0] infrared_count;
    } t_in_item;

    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic             is_light;
        logic             zero_count_error;
    } t_out_item;

    // per-item data carried down the pipeline
    typedef struct packed {
        logic [COUNT_W-1:0] ch0;
        logic [COUNT_W-1:0] ch1;
        t_band              band;
        logic               err;
    } t_meta;

endpackage

>>> rtl/lcc_div_cell.sv
// One restoring-division cell: produces one ratio quotient bit per stage.
module lcc_div_cell #(
    parameter int RATIO_FRAC_BITS = lcc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  lcc_pkg::t_meta                      i_meta,
    input  logic [lcc_pkg::COUNT_W-1:0]         i_rem,
    input  logic [RATIO_FRAC_BITS-1:0]          i_quo,
    output logic                                o_valid,
    output lcc_pkg::t_meta                      o_meta,
    output logic [lcc_pkg::COUNT_W-1:0]         o_rem,
    output logic [RATIO_FRAC_BITS-1:0]          o_quo
);
    import lcc_pkg::*;

    logic                       r_valid;
    t_meta                      r_meta;
    logic [COUNT_W-1:0]         r_rem;
    logic [RATIO_FRAC_BITS-1:0] r_quo;
    logic [COUNT_W:0]           w_shift;
    logic [COUNT_W:0]           w_sub;
    logic [COUNT_W-1:0]         n_rem;
    logic [RATIO_FRAC_BITS-1:0] n_quo;

    // shift, trial subtract, restore
    always_comb begin
        w_shift = {i_rem, 1'b0};
        w_sub   = w_shift - {1'b0, i_meta.ch0};
        if (w_shift >= {1'b0, i_meta.ch0}) begin
            n_rem = w_sub[COUNT_W-1:0];
            n_quo = {i_quo[RATIO_FRAC_BITS-2:0], 1'b1};
        end else begin
            n_rem = w_shift[COUNT_W-1:0];
            n_quo = {i_quo[RATIO_FRAC_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta <= i_meta;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

>>> rtl/lcc_pow_interp.sv
// r^1.4 lookup with linear interpolation, two pipeline stages.
module lcc_pow_interp #(
    parameter int RATIO_FRAC_BITS   = lcc_pkg::RATIO_FRAC_BITS_DEF,
    parameter int POWER_TABLE_DEPTH = lcc_pkg::POWER_TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  lcc_pkg::t_meta                 i_meta,
    input  logic [RATIO_FRAC_BITS-1:0]     i_ratio,
    output logic                           o_valid,
    output lcc_pkg::t_meta                 o_meta,
    output logic [lcc_pkg::POW_W-1:0]      o_pow
);
    import lcc_pkg::*;

    localparam int SCALE  = 2 * POWER_TABLE_DEPTH;
    localparam int SCL_W  = $clog2(SCALE + 1);
    localparam int POS_W  = RATIO_FRAC_BITS + SCL_W;
    localparam int IDX_W  = POS_W - RATIO_FRAC_BITS;
    localparam int TIDX_W = $clog2(POWER_TABLE_DEPTH + 1);

    // largest y below 2^14 with y^5 <= 2^63 * (k/D)^7, floored at each step
    function automatic logic [POW_W-1:0] f_pow(input int k);
        logic [127:0]     v;
        logic [127:0]     c;
        logic [127:0]     c5;
        logic [POW_W-1:0] y;
        v = 128'd1 << 63;
        y = '0;
        for (int i = 0; i < 7; i++) begin
            v = (v * k) / POWER_TABLE_DEPTH;
        end
        for (int b = POW_W - 1; b >= 0; b--) begin
            c  = {{(128-POW_W){1'b0}}, y | (POW_W'(1) << b)};
            c5 = c * c * c * c * c;
            if (c5 <= v) begin
                y = c[POW_W-1:0];
            end
        end
        return y;
    endfunction

    logic [POW_W-1:0] w_tbl [0:POWER_TABLE_DEPTH];

    for (genvar g = 0; g <= POWER_TABLE_DEPTH; g++) begin : g_tbl
        assign w_tbl[g] = f_pow(g);
    end

    logic [POS_W-1:0]           w_pos;
    logic [IDX_W-1:0]           w_idx;
    logic [RATIO_FRAC_BITS-1:0] w_frac;
    logic [TIDX_W-1:0]          w_tidx;
    logic [POW_W-1:0]           n_lo;
    logic [POW_W-1:0]           n_diff;
    logic [RATIO_FRAC_BITS-1:0] n_frac;

    // stage 1: table position, two reads
    always_comb begin
        w_pos  = POS_W'(i_ratio) * POS_W'(SCALE);
        w_idx  = w_pos[POS_W-1:RATIO_FRAC_BITS];
        w_frac = w_pos[RATIO_FRAC_BITS-1:0];
        if (w_idx >= IDX_W'(POWER_TABLE_DEPTH)) begin
            w_tidx = TIDX_W'(POWER_TABLE_DEPTH);
            n_lo   = w_tbl[w_tidx];
            n_diff = '0;
            n_frac = '0;
        end else begin
            w_tidx = w_idx[TIDX_W-1:0];
            n_lo   = w_tbl[w_tidx];
            n_diff = w_tbl[w_tidx + TIDX_W'(1)] - w_tbl[w_tidx];
            n_frac = w_frac;
        end
    end

    logic                       r_v1;
    t_meta                      r_m1;
    logic [POW_W-1:0]           r_lo;
    logic [POW_W-1:0]           r_diff;
    logic [RATIO_FRAC_BITS-1:0] r_frac;
    logic                       r_v2;
    t_meta                      r_m2;
    logic [POW_W-1:0]           r_pow;
    logic [POW_W+RATIO_FRAC_BITS-1:0] w_prod;
    logic [POW_W-1:0]           n_pow;

    // stage 2: interpolate with floored fraction
    always_comb begin
        w_prod = (POW_W+RATIO_FRAC_BITS)'(r_diff) * (POW_W+RATIO_FRAC_BITS)'(r_frac);
        n_pow  = r_lo + w_prod[POW_W+RATIO_FRAC_BITS-1:RATIO_FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= i_meta;
            r_lo   <= n_lo;
            r_diff <= n_diff;
            r_frac <= n_frac;
            r_m2   <= r_m1;
            r_pow  <= n_pow;
        end
    end

    assign o_valid = r_v2;
    assign o_meta  = r_m2;
    assign o_pow   = r_pow;

endmodule

>>> rtl/two_channel_lux_calculator_core.sv
// Top level: band select, ratio divider chain, power lookup, lux datapath.
// Throughput: one item per cycle; the divider is a chain of one-bit cells.
// The whole pipeline holds while a result is stalled at the output register.
// Reset (synchronous, active low) clears all valid bits and the light threshold.
module two_channel_lux_calculator_core #(
    parameter int LUX_FRAC_BITS     = lcc_pkg::LUX_FRAC_BITS_DEF,
    parameter int RATIO_FRAC_BITS   = lcc_pkg::RATIO_FRAC_BITS_DEF,
    parameter int POWER_TABLE_DEPTH = lcc_pkg::POWER_TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  lcc_pkg::t_in_item          i_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output lcc_pkg::t_out_item         o_out,
    input  logic                       i_cfg_we,
    input  logic [lcc_pkg::LUX_W-1:0]  i_cfg_wdata
);
    import lcc_pkg::*;

    localparam int SHIFT = COEF_FRAC - LUX_FRAC_BITS;
    localparam int SUM_W = PROD_W + 1;

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // threshold register
    logic [LUX_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // input stage: band decision by cross-multiplication
    logic [23:0] w_c100;
    logic [23:0] w_ch0;
    t_meta       n_m0;
    always_comb begin
        w_c100 = 24'(i_in.infrared_count) * 24'd100;
        w_ch0  = 24'(i_in.broadband_count);
        n_m0.ch0 = i_in.broadband_count;
        n_m0.ch1 = i_in.infrared_count;
        n_m0.err = (i_in.broadband_count == '0);
        if (w_c100 <= w_ch0 * 24'd50) begin
            n_m0.band = BAND_POW;
        end else if (w_c100 <= w_ch0 * 24'd61) begin
            n_m0.band = BAND_LIN2;
        end else if (w_c100 <= w_ch0 * 24'd80) begin
            n_m0.band = BAND_LIN3;
        end else if (w_c100 <= w_ch0 * 24'd130) begin
            n_m0.band = BAND_LIN4;
        end else begin
            n_m0.band = BAND_ZERO;
        end
    end

    logic  r_v0;
    t_meta r_m0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0 <= n_m0;
        end
    end

    // divider chain; ratio only matters when ch1 < ch0
    logic                       w_dv   [0:RATIO_FRAC_BITS];
    t_meta                      w_dm   [0:RATIO_FRAC_BITS];
    logic [COUNT_W-1:0]         w_drem [0:RATIO_FRAC_BITS];
    logic [RATIO_FRAC_BITS-1:0] w_dquo [0:RATIO_FRAC_BITS];

    assign w_dv[0]   = r_v0;
    assign w_dm[0]   = r_m0;
    assign w_drem[0] = (r_m0.ch1 < r_m0.ch0) ? r_m0.ch1 : '0;
    assign w_dquo[0] = '0;

    for (genvar g = 0; g < RATIO_FRAC_BITS; g++) begin : g_div
        lcc_div_cell #(
            .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_meta  (w_dm[g]),
            .i_rem   (w_drem[g]),
            .i_quo   (w_dquo[g]),
            .o_valid (w_dv[g+1]),
            .o_meta  (w_dm[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_quo   (w_dquo[g+1])
        );
    end

    // power term lookup
    logic             w_pv;
    t_meta            w_pm;
    logic [POW_W-1:0] w_pow;
    lcc_pow_interp #(
        .RATIO_FRAC_BITS   (RATIO_FRAC_BITS),
        .POWER_TABLE_DEPTH (POWER_TABLE_DEPTH)
    ) u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv[RATIO_FRAC_BITS]),
        .i_meta  (w_dm[RATIO_FRAC_BITS]),
        .i_ratio (w_dquo[RATIO_FRAC_BITS]),
        .o_valid (w_pv),
        .o_meta  (w_pm),
        .o_pow   (w_pow)
    );

    // first multiply stage: coefficient products
    logic [19:0]       w_ca;
    logic [19:0]       w_cb;
    always_comb begin
        case (w_pm.band)
            BAND_LIN2: begin
                w_ca = C_A2;
                w_cb = C_B2;
            end
            BAND_LIN3: begin
                w_ca = C_A3;
                w_cb = C_B3;
            end
            BAND_LIN4: begin
                w_ca = C_A4;
                w_cb = C_B4;
            end
            default: begin
                w_ca = C_A1;
                w_cb = C_B2;
            end
        endcase
    end

    logic              r_v1;
    t_meta             r_m1;
    logic [PROD_W-1:0] r_la1;
    logic [PROD_W-1:0] r_lb1;
    logic [PROD_W-1:0] r_t1;
    logic [POW_W-1:0]  r_pow1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1   <= w_pm;
            r_la1  <= PROD_W'(w_pm.ch0) * PROD_W'(w_ca);
            r_lb1  <= PROD_W'(w_pm.ch1) * PROD_W'(w_cb);
            r_t1   <= PROD_W'(w_pm.ch0) * PROD_W'(C_B1);
            r_pow1 <= w_pow;
        end
    end

    // second multiply stage: power product
    logic [PROD_W+POW_W-1:0] w_pp;
    assign w_pp = (PROD_W+POW_W)'(r_t1) * (PROD_W+POW_W)'(r_pow1);

    logic              r_v2;
    t_meta             r_m2;
    logic [PROD_W-1:0] r_la2;
    logic [PROD_W-1:0] r_lb2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2  <= r_m1;
            r_la2 <= r_la1;
            r_lb2 <= (r_m1.band == BAND_POW) ? w_pp[PROD_W+POW_W-1:POW_W] : r_lb1;
        end
    end

    // final stage: clamp, round, saturate, threshold compare
    logic [PROD_W-1:0] w_q24;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_full;
    t_out_item         n_out;
    always_comb begin
        if (r_m2.err || r_m2.band == BAND_ZERO || r_la2 <= r_lb2) begin
            w_q24 = '0;
        end else begin
            w_q24 = r_la2 - r_lb2;
        end
        w_sum  = SUM_W'(w_q24) + (SUM_W'(1) << (SHIFT - 1));
        w_full = w_sum >> SHIFT;
        if (r_m2.err) begin
            n_out.lux = '0;
        end else if (w_full > SUM_W'({LUX_W{1'b1}})) begin
            n_out.lux = {LUX_W{1'b1}};
        end else begin
            n_out.lux = w_full[LUX_W-1:0];
        end
        n_out.is_light         = (n_out.lux > r_thr);
        n_out.zero_count_error = r_m2.err;
    end

    logic      r_ov;
    t_out_item r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_pv;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_out   = r_out;

    // error items carry zero lux and dark
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.zero_count_error |-> o_out.lux == '0 && !o_out.is_light)
        else $error("error item with nonzero lux");

    // a stalled result holds the pipeline
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled result changed");

    // light flag agrees with threshold
    a_light: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(i_cfg_we) && !i_cfg_we |-> o_out.is_light == (o_out.lux > r_thr))
        else $error("light flag mismatch");

endmodule

>>> tb/two_channel_lux_calculator_core_chk.sv
// Checker for the lux calculator: predicts each item's result and compares it.
`timescale 1ns / 100ps
module two_channel_lux_calculator_core_chk (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  lcc_pkg::t_in_item         i_in,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  lcc_pkg::t_out_item        i_out,
    input  logic                      i_cfg_we,
    input  logic [lcc_pkg::LUX_W-1:0] i_cfg_wdata,
    output int                        o_errors,
    output int                        o_pending
);
    import lcc_pkg::*;

    localparam int DEPTH   = POWER_TABLE_DEPTH_DEF;
    localparam int RFRAC   = RATIO_FRAC_BITS_DEF;
    localparam int LFRAC   = LUX_FRAC_BITS_DEF;
    localparam longint unsigned LUX_TOP = (64'd1 << LUX_W) - 1;

    longint unsigned pow_tab [0:DEPTH];
    logic [LUX_W-1:0] threshold;
    t_out_item        lux_expected [$];

    // r^1.4 table entry: largest y with y^5 <= 2^63*(k/D)^7
    function automatic longint unsigned power_point(longint unsigned k);
        longint unsigned v;
        longint unsigned y;
        longint unsigned c;
        v = 64'd1 << 63;
        y = 0;
        for (int i = 0; i < 7; i++)
            v = (v / DEPTH) * k + ((v % DEPTH) * k) / DEPTH;
        for (int b = POW_W - 1; b >= 0; b--) begin
            c = y | (64'd1 << b);
            if (c * c * c * c <= v / c)
                y = c;
        end
        return y;
    endfunction

    // interpolated r^1.4 in Q.14
    function automatic longint unsigned ratio_power(longint unsigned ch0, longint unsigned ch1);
        longint unsigned rq;
        longint unsigned p;
        longint unsigned idx;
        longint unsigned frac;
        rq   = (ch1 << RFRAC) / ch0;
        p    = rq * 2 * DEPTH;
        idx  = p >> RFRAC;
        frac = p & ((64'd1 << RFRAC) - 1);
        if (idx >= DEPTH)
            return pow_tab[DEPTH];
        return pow_tab[idx] + (((pow_tab[idx+1] - pow_tab[idx]) * frac) >> RFRAC);
    endfunction

    function automatic longint unsigned clamp_sub(longint unsigned a, longint unsigned b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic t_out_item lux_of(t_in_item it, logic [LUX_W-1:0] thr);
        longint unsigned ch0;
        longint unsigned ch1;
        longint unsigned q24;
        longint unsigned lx;
        t_out_item       r;
        ch0 = it.broadband_count;
        ch1 = it.infrared_count;
        q24 = 0;
        lx  = 0;
        r.zero_count_error = (ch0 == 0);
        if (ch0 != 0) begin
            if (ch1 * 100 <= ch0 * 50)
                q24 = clamp_sub(ch0 * C_A1, (ch0 * C_B1 * ratio_power(ch0, ch1)) >> POW_W);
            else if (ch1 * 100 <= ch0 * 61)
                q24 = clamp_sub(ch0 * C_A2, ch1 * C_B2);
            else if (ch1 * 100 <= ch0 * 80)
                q24 = clamp_sub(ch0 * C_A3, ch1 * C_B3);
            else if (ch1 * 100 <= ch0 * 130)
                q24 = clamp_sub(ch0 * C_A4, ch1 * C_B4);
            lx = (q24 + (64'd1 << (COEF_FRAC - LFRAC - 1))) >> (COEF_FRAC - LFRAC);
            if (lx > LUX_TOP)
                lx = LUX_TOP;
        end
        r.lux      = lx[LUX_W-1:0];
        r.is_light = (lx > thr);
        return r;
    endfunction

    initial begin
        for (int k = 0; k <= DEPTH; k++)
            pow_tab[k] = power_point(k);
    end

    assign o_pending = lux_expected.size();

    // predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            threshold <= '0;
            o_errors = 0;
            lux_expected.delete();
        end else begin
            if (i_cfg_we)
                threshold <= i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                lux_expected.push_back(lux_of(i_in, threshold));
            if (i_out_valid && !i_out_stall) begin
                if (lux_expected.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected item: lux=%0d light=%0b err=%0b",
                                 i_out.lux, i_out.is_light, i_out.zero_count_error);
                end else begin
                    want = lux_expected.pop_front();
                    if (want !== i_out) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: exp lux=%0d light=%0b err=%0b, got lux=%0d light=%0b err=%0b",
                                     want.lux, want.is_light, want.zero_count_error,
                                     i_out.lux, i_out.is_light, i_out.zero_count_error);
                    end
                end
            end
        end
    end
endmodule

>>> tb/two_channel_lux_calculator_core_tb.sv
// Testbench top: stimulus, stall patterns and the final verdict for the lux calculator.
`timescale 1ns / 100ps
module two_channel_lux_calculator_core_tb;
    import lcc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    t_in_item         i_in = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    t_out_item        o_out;
    logic             i_cfg_we = 1'b0;
    logic [LUX_W-1:0] i_cfg_wdata = '0;
    int               mismatches;
    int               waiting;
    int               cycles = 0;
    int               burst_left = 0;

    always #5 i_clk = ~i_clk;

    two_channel_lux_calculator_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    two_channel_lux_calculator_core_chk i_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_stall (o_stall),
        .i_in       (i_in),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_errors   (mismatches),
        .o_pending  (waiting)
    );

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall: rotates through four modes
    always @(posedge i_clk) begin
        case ((cycles / 64) % 4)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(1, 0) == 1);
            2: i_stall <= ($urandom_range(9, 0) < 8);
            default: i_stall <= ((cycles % 7) < 2);
        endcase
    end

    // one item, in bursts with random gaps between them
    task automatic send_counts(logic [COUNT_W-1:0] ch0, logic [COUNT_W-1:0] ch1);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 1);
            gap = $urandom_range(6, 0);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_in.broadband_count <= ch0;
        i_in.infrared_count  <= ch1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_and_set(logic [LUX_W-1:0] thr);
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random item: band-targeted ratios, small counts or fully random counts
    task automatic send_random();
        int unsigned ch0;
        int unsigned ch1;
        int unsigned k;
        case ($urandom_range(3, 0))
            0: begin
                ch0 = $urandom_range(65535, 0);
                ch1 = $urandom_range(65535, 0);
            end
            1: begin
                ch0 = $urandom_range(40, 0);
                ch1 = $urandom_range(60, 0);
            end
            default: begin
                ch0 = $urandom_range(65535, 1);
                k   = $urandom_range(1400, 0);
                ch1 = (ch0 * k) / 1000 + $urandom_range(2, 0);
                if (ch1 > 65535) ch1 = 65535;
            end
        endcase
        send_counts(ch0[15:0], ch1[15:0]);
    endtask

    int unsigned thr_list [5] = '{0, 524287, 256, 4000, 100000};

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero broadband, extremes, exact band edges, beyond 1.30
        send_counts(16'd0, 16'd0);
        send_counts(16'd0, 16'hFFFF);
        send_counts(16'hFFFF, 16'd0);
        send_counts(16'hFFFF, 16'hFFFF);
        send_counts(16'd1, 16'hFFFF);
        send_counts(16'd1, 16'd0);
        send_counts(16'd100, 16'd50);
        send_counts(16'd100, 16'd51);
        send_counts(16'd100, 16'd61);
        send_counts(16'd100, 16'd62);
        send_counts(16'd100, 16'd80);
        send_counts(16'd100, 16'd81);
        send_counts(16'd100, 16'd130);
        send_counts(16'd100, 16'd131);
        send_counts(16'd65500, 16'd32750);
        send_counts(16'd50000, 16'd65000);
        send_counts(16'd4096, 16'd2047);
        send_counts(16'h5555, 16'h2AAA);
        send_counts(16'hAAAA, 16'h5555);

        // random phases across several threshold settings
        foreach (thr_list[t]) begin
            drain_and_set(thr_list[t][LUX_W-1:0]);
            repeat (300) send_random();
        end
        drain_and_set(LUX_W'($urandom_range(524287, 0)));
        repeat (100) send_random();

        i_valid <= 1'b0;
        while (waiting != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && waiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
